// ===== hw/rtl/qtok_pkg.sv =====
// Shared constants and types of the quoted-string tokeniser.
package qtok_pkg;

	localparam int MAX_SEPARATORS = 8;
	localparam int MAX_QUOTES     = 4;

	localparam int BYTE_W      = 8;
	localparam int SEP_CHARS_W = MAX_SEPARATORS * BYTE_W;
	localparam int SEP_CNT_W   = 4;
	localparam int QUO_CHARS_W = MAX_QUOTES * BYTE_W;
	localparam int QUO_CNT_W   = 3;
	localparam int TOK_CNT_W   = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [SEP_CHARS_W-1:0] SEP_CHARS_RST = SEP_CHARS_W'(64'h0A0D_0920);
	localparam logic [SEP_CNT_W-1:0]   SEP_CNT_RST   = SEP_CNT_W'(4);
	localparam logic [QUO_CHARS_W-1:0] QUO_CHARS_RST = QUO_CHARS_W'(32'h22);
	localparam logic [QUO_CNT_W-1:0]   QUO_CNT_RST   = QUO_CNT_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEP_CHARS = 3'd0,
		REG_SEP_COUNT = 3'd1,
		REG_QUO_CHARS = 3'd2,
		REG_QUO_COUNT = 3'd3,
		REG_TOK_LIMIT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              content;
		logic              done;
		logic              quoted;
		logic              unclosed;
	} result_t;

endpackage

// ===== hw/rtl/quoted_tokenizer.sv =====
// Top level of the quoted-string tokeniser: input stage, token state and result register.
//
// The block takes one character per transaction and returns one tagged result per character,
// held first in the input stage and then in the result register. A new character can be taken
// in every cycle unless the output stalls: the per-string state (open token, open quote,
// token count, remainder mode) is updated in the single cycle in which a character moves from
// the input stage into the result register, and the separator and quote compares run in parallel over all slots.
// Configuration writes are always taken and must be made only while no character is in flight.
module quoted_tokenizer
	import qtok_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BYTE_W-1:0]     in_byte,
	input  logic                  end_of_string,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BYTE_W-1:0]     out_byte,
	output logic                  is_content,
	output logic                  token_done,
	output logic                  was_quoted,
	output logic                  quote_unclosed,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SEP_CHARS_W-1:0] sep_chars_q;
	logic [SEP_CNT_W-1:0]   sep_count_q;
	logic [QUO_CHARS_W-1:0] quo_chars_q;
	logic [QUO_CNT_W-1:0]   quo_count_q;
	logic [TOK_CNT_W-1:0]   tok_limit_q;

	logic                   quote_open_q, quote_open_n;
	logic [BYTE_W-1:0]      open_quote_q, open_quote_n;
	logic                   token_open_q, token_open_n;
	logic [TOK_CNT_W-1:0]   tokens_q, tokens_n;
	logic                   remainder_q, remainder_n;

	logic                   valid_s1;
	logic [BYTE_W-1:0]      byte_s1;
	logic                   eos_s1;

	logic                   valid_s2;
	result_t                res_s2;
	result_t                res_n;

	logic                   advance;
	logic                   is_sep;
	logic                   is_quo;
	logic [TOK_CNT_W-1:0]   tokens_inc;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_chars_q <= SEP_CHARS_RST;
			sep_count_q <= SEP_CNT_RST;
			quo_chars_q <= QUO_CHARS_RST;
			quo_count_q <= QUO_CNT_RST;
			tok_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SEP_CHARS: sep_chars_q <= cfg_data[SEP_CHARS_W-1:0];
				REG_SEP_COUNT: sep_count_q <= cfg_data[SEP_CNT_W-1:0];
				REG_QUO_CHARS: quo_chars_q <= cfg_data[QUO_CHARS_W-1:0];
				REG_QUO_COUNT: quo_count_q <= cfg_data[QUO_CNT_W-1:0];
				REG_TOK_LIMIT: tok_limit_q <= cfg_data[TOK_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// A count above the number of slots simply enables every slot.
	always_comb begin
		is_sep = 1'b0;
		for (int i = 0; i < MAX_SEPARATORS; i++) begin
			if ((SEP_CNT_W'(i) < sep_count_q) && (sep_chars_q[i*BYTE_W +: BYTE_W] == byte_s1))
				is_sep = 1'b1;
		end
		is_quo = 1'b0;
		for (int j = 0; j < MAX_QUOTES; j++) begin
			if ((QUO_CNT_W'(j) < quo_count_q) && (quo_chars_q[j*BYTE_W +: BYTE_W] == byte_s1))
				is_quo = 1'b1;
		end
	end

	assign tokens_inc = (tokens_q != '1) ? tokens_q + TOK_CNT_W'(1) : tokens_q;

	always_comb begin
		res_n          = '0;
		res_n.data     = byte_s1;
		quote_open_n   = quote_open_q;
		open_quote_n   = open_quote_q;
		token_open_n   = token_open_q;
		tokens_n       = tokens_q;
		remainder_n    = remainder_q;

		if (remainder_q) begin
			res_n.content = 1'b1;
			res_n.quoted  = quote_open_q;
		end else if (quote_open_q) begin
			res_n.quoted = 1'b1;
			if (byte_s1 == open_quote_q) begin
				res_n.done   = 1'b1;
				quote_open_n = 1'b0;
				token_open_n = 1'b0;
				open_quote_n = '0;
				tokens_n     = tokens_inc;
			end else begin
				res_n.content = 1'b1;
			end
		end else if (token_open_q) begin
			if (is_sep || is_quo) begin
				res_n.done   = 1'b1;
				token_open_n = 1'b0;
				tokens_n     = tokens_inc;
			end else begin
				res_n.content = 1'b1;
			end
		end else if (!is_sep) begin
			token_open_n = 1'b1;
			if ((tok_limit_q != '0) && (tokens_q == tok_limit_q))
				remainder_n = 1'b1;
			if (is_quo) begin
				quote_open_n = 1'b1;
				open_quote_n = byte_s1;
				res_n.quoted = 1'b1;
			end else begin
				res_n.content = 1'b1;
			end
		end

		if (eos_s1) begin
			if (token_open_n) begin
				res_n.done = 1'b1;
				if (quote_open_n && !remainder_n)
					res_n.unclosed = 1'b1;
			end
			quote_open_n = 1'b0;
			open_quote_n = '0;
			token_open_n = 1'b0;
			tokens_n     = '0;
			remainder_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			quote_open_q <= 1'b0;
			open_quote_q <= '0;
			token_open_q <= 1'b0;
			tokens_q     <= '0;
			remainder_q  <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;

			if (advance) begin
				quote_open_q <= quote_open_n;
				open_quote_q <= open_quote_n;
				token_open_q <= token_open_n;
				tokens_q     <= tokens_n;
				remainder_q  <= remainder_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_string;
		end
		if (advance)
			res_s2 <= res_n;
	end

	assign out_valid      = valid_s2;
	assign out_byte       = res_s2.data;
	assign is_content     = res_s2.content;
	assign token_done     = res_s2.done;
	assign was_quoted     = res_s2.quoted;
	assign quote_unclosed = res_s2.unclosed;

	a_unclosed_ends_token: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.unclosed) |-> res_s2.done)
		else $error("unclosed quote flagged without a token end");

	a_remainder_in_token: assert property (@(posedge clk) disable iff (!arst_n)
		remainder_q |-> token_open_q)
		else $error("remainder mode outside an open token");

	a_eos_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eos_s1) |=> (!token_open_q && !quote_open_q && tokens_q == '0))
		else $error("string state not cleared after the final character");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked item");

endmodule
